>>> rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

    typedef struct packed {
        logic        cmd;
        logic [19:0] raw_value;
    } ptc_in_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] temperature_centi;
        logic        [31:0] pressure_q24_8;
        logic               divide_by_zero;
    } ptc_out_t;

    localparam int StepW = 5;
    typedef logic [StepW-1:0] ptc_step_t;

    // Temperature program.
    localparam ptc_step_t ST_0  = 5'd0;
    localparam ptc_step_t ST_1  = 5'd1;
    localparam ptc_step_t ST_2  = 5'd2;
    localparam ptc_step_t ST_F  = 5'd3;
    // Pressure program.
    localparam ptc_step_t SP_0  = 5'd4;
    localparam ptc_step_t SP_1  = 5'd5;
    localparam ptc_step_t SP_2  = 5'd6;
    localparam ptc_step_t SP_3  = 5'd7;
    localparam ptc_step_t SP_4  = 5'd8;
    localparam ptc_step_t SP_5  = 5'd9;
    localparam ptc_step_t SP_6  = 5'd10;
    localparam ptc_step_t SP_7  = 5'd11;
    localparam ptc_step_t SP_8  = 5'd12;
    localparam ptc_step_t SP_9  = 5'd13;
    localparam ptc_step_t SP_10 = 5'd14;
    localparam ptc_step_t SP_11 = 5'd15;
    localparam ptc_step_t SP_12 = 5'd16;
    localparam ptc_step_t SP_13 = 5'd17;
    localparam ptc_step_t SP_14 = 5'd18;
    localparam ptc_step_t SP_15 = 5'd19;
    localparam ptc_step_t SP_16 = 5'd20;
    localparam ptc_step_t SP_17 = 5'd21;
    localparam ptc_step_t SP_18 = 5'd22;

    localparam logic [1:0] KIND_ALU = 2'd0;
    localparam logic [1:0] KIND_MUL = 2'd1;
    localparam logic [1:0] KIND_DIV = 2'd2;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [20:0] RAW_FULL    = 21'd1048576;
    localparam logic [63:0] SCALE_3125  = 64'd3125;

    typedef struct packed {
        logic      load;
        logic      go_mul;
        logic      go_div;
        logic      exec;
        logic      finish;
        ptc_step_t step;
    } ptc_cmd_t;

    typedef struct packed {
        logic in_cmd;
        logic mul_done;
        logic div_done;
        logic v1_zero;
        logic out_free;
    } ptc_stat_t;

    function automatic logic [1:0] step_kind(input ptc_step_t step);
        logic [1:0] kind;
        case (step) inside
            ST_0, ST_1, ST_2, SP_1, SP_2, SP_3, SP_5, SP_6, SP_8, SP_10,
            SP_13, SP_14, SP_15: kind = KIND_MUL;
            SP_11:               kind = KIND_DIV;
            default:             kind = KIND_ALU;
        endcase
        return kind;
    endfunction

    function automatic logic last_step(input ptc_step_t step);
        return (step == ST_F) || (step == SP_18);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] v, input int unsigned s);
        return 64'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

>>> rtl/ptc_mul.sv
`default_nettype none
module ptc_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      prod
);
    // Low 64 bits of a 64x64 product from three 32x32 partial products.
    logic [2:0]  cnt_reg, cnt_next;
    logic        done_reg;
    logic [63:0] a_reg, b_reg, acc_reg, pp_reg;
    logic [31:0] ma, mb;

    always_comb begin
        case (cnt_reg)
            3'd1: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            3'd2: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            default: begin ma = a_reg[63:32]; mb = b_reg[31:0]; end
        endcase
        if (start) begin
            cnt_next = 3'd1;
        end else if (cnt_reg == 3'd4) begin
            cnt_next = 3'd0;
        end else if (cnt_reg != 3'd0) begin
            cnt_next = 3'(cnt_reg + 3'd1);
        end else begin
            cnt_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= (cnt_reg == 3'd4);
        end
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        pp_reg <= ma * mb;
        case (cnt_reg)
            3'd2: acc_reg <= pp_reg;
            3'd3, 3'd4: acc_reg[63:32] <= acc_reg[63:32] + pp_reg[31:0];
            default: ;
        endcase
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

>>> rtl/ptc_div.sv
`default_nettype none
module ptc_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quo
);
    // Signed division truncating toward zero: restoring, one bit per cycle.
    logic [6:0]  cnt_reg;
    logic        done_reg, neg_reg;
    logic [63:0] q_reg, rem_reg, md_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, q_reg[63]} - {1'b0, md_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 7'd1);
            if (start) begin
                cnt_reg <= 7'd64;
            end else if (cnt_reg != 7'd0) begin
                cnt_reg <= 7'(cnt_reg - 7'd1);
            end
        end
        if (start) begin
            neg_reg <= num[63] ^ den[63];
            q_reg   <= num[63] ? 64'(64'd0 - num) : num;
            md_reg  <= den[63] ? 64'(64'd0 - den) : den;
            rem_reg <= 64'd0;
        end else if (cnt_reg != 7'd0) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[62:0], q_reg[63]};
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? 64'(64'd0 - q_reg) : q_reg;
endmodule
`default_nettype wire

>>> rtl/ptc_ctrl.sv
`default_nettype none
module ptc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ptc_pkg::ptc_stat_t stat,
    output ptc_pkg::ptc_cmd_t      cmd
);
    import ptc_pkg::*;

    localparam logic [1:0] IDLE   = 2'd0;
    localparam logic [1:0] ISSUE  = 2'd1;
    localparam logic [1:0] WAIT   = 2'd2;
    localparam logic [1:0] FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    ptc_step_t  step_reg, step_next;
    ptc_step_t  step_inc;

    assign step_inc = StepW'(step_reg + 1'b1);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = stat.in_cmd ? SP_0 : ST_0;
                    state_next = ISSUE;
                end
            end
            ISSUE: begin
                unique case (step_kind(step_reg))
                    KIND_MUL: begin
                        cmd.go_mul = 1'b1;
                        state_next = WAIT;
                    end
                    KIND_DIV: begin
                        cmd.go_div = 1'b1;
                        state_next = WAIT;
                    end
                    default: begin
                        cmd.exec = 1'b1;
                        // A zero divisor ends the pressure program early.
                        if (last_step(step_reg) || (step_reg == SP_9 && stat.v1_zero)) begin
                            state_next = FINISH;
                        end else begin
                            step_next = step_inc;
                        end
                    end
                endcase
            end
            WAIT: begin
                if (stat.mul_done || stat.div_done) begin
                    cmd.exec   = 1'b1;
                    step_next  = step_inc;
                    state_next = ISSUE;
                end
            end
            FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            step_reg  <= ST_0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ptc_datapath.sv
`default_nettype none
module ptc_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ptc_pkg::ptc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ptc_pkg::ptc_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata,
    input  wire ptc_pkg::ptc_cmd_t cmd,
    output ptc_pkg::ptc_stat_t     stat
);
    import ptc_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_a_reg, press_b_reg;
    logic [15:0] press_c_reg;
    logic [31:0] fine_reg;
    logic [19:0] raw_reg;
    logic        kind_reg;
    logic [63:0] ta_reg, tb_reg, v1_reg, v2_reg, m1_reg, p_reg;
    logic signed [31:0] temp_res_reg;
    logic [31:0] press_res_reg;
    logic        dz_reg;
    logic        m_valid_reg;
    ptc_out_t    out_reg;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] mul_a, mul_b, prod, quo;
    logic        mul_done, div_done;
    logic [63:0] tf;
    logic signed [35:0] t5;
    logic [20:0] pdiff;
    logic [63:0] pfin;

    assign t1 = {48'd0, temp_calib_reg[15:0]};
    assign t2 = sx16(temp_calib_reg[31:16]);
    assign t3 = sx16(temp_calib_reg[47:32]);
    assign p1 = {48'd0, press_a_reg[15:0]};
    assign p2 = sx16(press_a_reg[31:16]);
    assign p3 = sx16(press_a_reg[47:32]);
    assign p4 = sx16(press_a_reg[63:48]);
    assign p5 = sx16(press_b_reg[15:0]);
    assign p6 = sx16(press_b_reg[31:16]);
    assign p7 = sx16(press_b_reg[47:32]);
    assign p8 = sx16(press_b_reg[63:48]);
    assign p9 = sx16(press_c_reg);

    always_comb begin
        case (cmd.step)
            ST_0: begin
                mul_a = {47'd0, raw_reg[19:3]} - {47'd0, t1[15:0], 1'b0};
                mul_b = t2;
            end
            ST_1: begin
                mul_a = {48'd0, raw_reg[19:4]} - t1;
                mul_b = mul_a;
            end
            ST_2:    begin mul_a = tb_reg; mul_b = t3;         end
            SP_1:    begin mul_a = v1_reg; mul_b = v1_reg;     end
            SP_2:    begin mul_a = m1_reg; mul_b = p6;         end
            SP_3:    begin mul_a = v1_reg; mul_b = p5;         end
            SP_5:    begin mul_a = m1_reg; mul_b = p3;         end
            SP_6:    begin mul_a = v1_reg; mul_b = p2;         end
            SP_8:    begin mul_a = v1_reg; mul_b = p1;         end
            SP_10:   begin mul_a = ta_reg; mul_b = SCALE_3125; end
            SP_13:   begin mul_a = p9;     mul_b = tb_reg;     end
            SP_14:   begin mul_a = ta_reg; mul_b = tb_reg;     end
            SP_15:   begin mul_a = p8;     mul_b = p_reg;      end
            default: begin mul_a = ta_reg; mul_b = tb_reg;     end
        endcase
    end

    ptc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.go_mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (prod)
    );

    ptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.go_div),
        .num     (ta_reg),
        .den     (v1_reg),
        .done    (div_done),
        .quo     (quo)
    );

    assign tf    = ta_reg + sra64(prod, 14);
    assign t5    = $signed({{4{fine_reg[31]}}, fine_reg})
                 + $signed({{2{fine_reg[31]}}, fine_reg, 2'b00}) + 36'sd128;
    assign pdiff = 21'(RAW_FULL - {1'b0, raw_reg});
    assign pfin  = sra64(p_reg, 8) + (p7 << 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
            fine_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TEMP:    temp_calib_reg <= cfg_wdata[47:0];
                    REG_PRESS_A: press_a_reg    <= cfg_wdata;
                    REG_PRESS_B: press_b_reg    <= cfg_wdata;
                    REG_PRESS_C: press_c_reg    <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.exec && cmd.step == ST_2) begin
                fine_reg <= tf[31:0];
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (cmd.load) begin
            raw_reg       <= s_data.raw_value;
            kind_reg      <= s_data.cmd;
            temp_res_reg  <= '0;
            press_res_reg <= '0;
            dz_reg        <= 1'b0;
        end
        if (cmd.exec) begin
            case (cmd.step)
                ST_0:  ta_reg <= sra64(prod, 11);
                ST_1:  tb_reg <= sra64(prod, 12);
                ST_F:  temp_res_reg <= $signed({{4{t5[35]}}, t5[35:8]});
                SP_0:  v1_reg <= {{32{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
                SP_1:  m1_reg <= prod;
                SP_2:  v2_reg <= prod;
                SP_3:  v2_reg <= v2_reg + (prod << 17);
                SP_4:  v2_reg <= v2_reg + (p4 << 35);
                SP_5:  ta_reg <= sra64(prod, 8);
                SP_6:  v1_reg <= ta_reg + (prod << 12);
                SP_7:  v1_reg <= v1_reg + (64'd1 << 47);
                SP_8:  v1_reg <= sra64(prod, 33);
                SP_9: begin
                    if (v1_reg == 64'd0) begin
                        dz_reg <= 1'b1;
                    end else begin
                        ta_reg <= {12'd0, pdiff, 31'd0} - v2_reg;
                    end
                end
                SP_10: ta_reg <= prod;
                SP_11: p_reg  <= quo;
                SP_12: tb_reg <= sra64(p_reg, 13);
                SP_13: ta_reg <= prod;
                SP_14: ta_reg <= sra64(prod, 25);
                SP_15: tb_reg <= sra64(prod, 19);
                SP_16: p_reg  <= p_reg + ta_reg;
                SP_17: p_reg  <= p_reg + tb_reg;
                SP_18: press_res_reg <= pfin[31:0];
                default: ;
            endcase
        end
        if (cmd.finish) begin
            out_reg.result_kind       <= kind_reg;
            out_reg.temperature_centi <= temp_res_reg;
            out_reg.pressure_q24_8    <= press_res_reg;
            out_reg.divide_by_zero    <= dz_reg;
        end
    end

    assign stat.in_cmd   = s_data.cmd;
    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.v1_zero  = (v1_reg == 64'd0);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

>>> rtl/pressure_temperature_compensation_top.sv
`default_nettype none
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   ptc_in_t  (cmd, raw_value)
// m_        out        m_valid / m_ready   ptc_out_t (kind, temperature, pressure, flag)
// cfg_      in         cfg_we              cfg_index selects, cfg_wdata carries value
//
// One word at a time. A pressure word whose divisor is zero ends before the division.
// Each 64-bit product is formed on one shared 32x32 multiplier, and the division
// yields one quotient bit per cycle.
// Reset clears the calibration registers and the kept fine temperature.
// A finished result waits in the output register while the next word is taken.
module pressure_temperature_compensation_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ptc_pkg::ptc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ptc_pkg::ptc_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata
);
    import ptc_pkg::*;

    ptc_cmd_t  cmd;
    ptc_stat_t stat;

    ptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in work");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.go_div |-> !stat.v1_zero)
        else $error("division started with zero divisor");

    a_single_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.go_mul && cmd.go_div))
        else $error("multiplier and divider started together");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
    import ptc_pkg::*;

    localparam int CMD_TEMP = 0;
    localparam int CMD_PRESS = 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 550;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ptc_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    ptc_out_t          m_data;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [63:0]       cfg_wdata;

    pressure_temperature_compensation_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Calibration and kept fine temperature as the predictor sees them.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    logic [31:0] fine_temp;

    ptc_in_t  pending_words[$];
    ptc_out_t expected_results[$];
    int       mismatches;
    int       tick_count;
    bit       quiet_stretch;
    bit       drive_enable;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] asr(input logic [63:0] v, input int s);
        return 64'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] signed_quotient(input logic [63:0] n,
                                                    input logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // Works out the compensated value for one word; a temperature word also updates fine_temp.
    function automatic ptc_out_t compensate(input ptc_in_t w);
        ptc_out_t    res;
        logic [63:0] r, t1, t2, t3, a, d, b, tf, v1, v2, p, ft;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        res = '0;
        r = 64'(w.raw_value);
        if (w.cmd == 1'(CMD_TEMP)) begin
            t1 = 64'(cal_temp[15:0]);
            t2 = sext16(cal_temp[31:16]);
            t3 = sext16(cal_temp[47:32]);
            a = asr(((r >> 3) - (t1 << 1)) * t2, 11);
            d = (r >> 4) - t1;
            b = asr(asr(d * d, 12) * t3, 14);
            tf = a + b;
            fine_temp = tf[31:0];
            ft = {{32{fine_temp[31]}}, fine_temp};
            res.temperature_centi = 32'(asr(ft * 64'd5 + 64'd128, 8));
        end else begin
            p1 = 64'(cal_press_a[15:0]);
            p2 = sext16(cal_press_a[31:16]);
            p3 = sext16(cal_press_a[47:32]);
            p4 = sext16(cal_press_a[63:48]);
            p5 = sext16(cal_press_b[15:0]);
            p6 = sext16(cal_press_b[31:16]);
            p7 = sext16(cal_press_b[47:32]);
            p8 = sext16(cal_press_b[63:48]);
            p9 = sext16(cal_press_c);
            res.result_kind = 1'b1;
            v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = asr(((64'd1 << 47) + v1) * p1, 33);
            if (v1 == 64'd0) begin
                res.divide_by_zero = 1'b1;
            end else begin
                p = 64'd1048576 - r;
                p = signed_quotient(((p << 31) - v2) * 64'd3125, v1);
                v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
                v2 = asr(p8 * p, 19);
                p = asr(p + v1 + v2, 8) + (p7 << 4);
                res.pressure_q24_8 = p[31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Driver: the predictor runs as each word is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            expected_results.push_back(compensate(s_data));
            void'(pending_words.pop_front());
            if (pending_words.size() != 0 && drive_enable &&
                (quiet_stretch || $urandom_range(99) >= 6)) begin
                s_data <= pending_words[0];
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid && pending_words.size() != 0 && drive_enable &&
                     (quiet_stretch || $urandom_range(99) >= 6)) begin
            s_valid <= 1'b1;
            s_data <= pending_words[0];
        end
    end

    // Back-pressure on the result side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_stretch || ($urandom_range(99) >= 6);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        ptc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 64'(m_data.result_kind),
                                    64'(want.result_kind));
                if (m_data.temperature_centi !== want.temperature_centi)
                    report_mismatch("temperature_centi",
                                    64'(m_data.temperature_centi),
                                    64'(want.temperature_centi));
                if (m_data.pressure_q24_8 !== want.pressure_q24_8)
                    report_mismatch("pressure_q24_8", 64'(m_data.pressure_q24_8),
                                    64'(want.pressure_q24_8));
                if (m_data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", 64'(m_data.divide_by_zero),
                                    64'(want.divide_by_zero));
            end
        end
    end

    always @(posedge aclk) begin
        tick_count <= tick_count + 1;
        if (tick_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_word(input int cmd, input logic [19:0] raw);
        ptc_in_t w;
        w.cmd = 1'(cmd);
        w.raw_value = raw;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TEMP:    cal_temp = val[47:0];
            REG_PRESS_A: cal_press_a = val;
            REG_PRESS_B: cal_press_b = val;
            default:     cal_press_c = val[15:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Runs the queued words and waits until the block is idle again.
    task automatic run_words();
        drive_enable = 1'b1;
        wait (pending_words.size() == 0 && expected_results.size() == 0);
        drive_enable = 1'b0;
        repeat (200) @(posedge aclk);
    endtask

    // Typical sensor calibration: realistic words keep the divisor nonzero.
    task automatic write_typical();
        write_reg(REG_TEMP, {16'hFC18, 16'(16'd26435 + $urandom_range(200)),
                             16'(16'd27504 + $urandom_range(2000))});
        write_reg(REG_PRESS_A, {16'd2855, 16'hD8F4, 16'd8364,
                                16'(16'd36477 + $urandom_range(2000))});
        write_reg(REG_PRESS_B, {16'hC1BE, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(REG_PRESS_C, 64'd6000);
    endtask

    initial begin
        logic [63:0] rv;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TEMP;
        cfg_wdata = '0;
        cal_temp = '0;
        cal_press_a = '0;
        cal_press_b = '0;
        cal_press_c = '0;
        fine_temp = '0;
        mismatches = 0;
        tick_count = 0;
        quiet_stretch = 1'b0;
        drive_enable = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Pressure before any temperature, with all calibration at zero: zero divisor.
        push_word(CMD_PRESS, 20'd0);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_PRESS, 20'hFFFFF);
        run_words();

        write_typical();
        push_word(CMD_TEMP, 20'd519888);
        push_word(CMD_PRESS, 20'd415148);
        push_word(CMD_PRESS, 20'd0);
        push_word(CMD_PRESS, 20'hFFFFF);
        push_word(CMD_TEMP, 20'd0);
        push_word(CMD_PRESS, 20'h55555);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_PRESS, 20'hAAAAA);
        run_words();

        // Extremes of every register, all ones then most negative words.
        write_reg(REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_C, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(CMD_TEMP, 20'd0);
        push_word(CMD_PRESS, 20'd1);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_PRESS, 20'hFFFFF);
        run_words();
        write_reg(REG_TEMP, 64'h8000_8000_0000);
        write_reg(REG_PRESS_A, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_B, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_C, 64'h8000);
        push_word(CMD_TEMP, 20'h80000);
        push_word(CMD_PRESS, 20'h7FFFF);
        push_word(CMD_TEMP, 20'd12345);
        push_word(CMD_PRESS, 20'd0);
        run_words();

        // Random phases: mostly realistic calibration, some fully random.
        for (int phase = 0; phase < 11; phase++) begin
            quiet_stretch = (phase == 4);
            if (phase % 3 == 2) begin
                rv = {$urandom, $urandom};
                write_reg(REG_TEMP, rv);
                write_reg(REG_PRESS_A, {$urandom, $urandom});
                write_reg(REG_PRESS_B, {$urandom, $urandom});
                write_reg(REG_PRESS_C, {32'h0, $urandom});
            end else begin
                write_typical();
            end
            for (int i = 0; i < RANDOM_WORDS / 11; i++) begin
                if ($urandom_range(3) == 0)
                    push_word(CMD_TEMP, 20'($urandom));
                else if ($urandom_range(9) == 0)
                    push_word(CMD_PRESS, 20'($urandom));
                else
                    push_word(CMD_PRESS, 20'(20'd200000 + $urandom_range(400000)));
            end
            run_words();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
